>>> rtl/tss_pkg.sv
// Shared types and constants for the ternary search unit.
package tss_pkg;

  // Element store geometry
  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;
  localparam int AW        = 10;  // store address bits
  localparam int LEN_W     = 11;  // used_length register width
  localparam int BND_W     = 12;  // signed search window bound, holds -1 .. DEPTH

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  // x/3 as (x * 683) >> 11, exact for x below 2048
  localparam int RECIP3   = 683;
  localparam int RECIP_SH = 11;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    logic                        kind;
    logic [AW-1:0]               slot;
    logic signed [WORD_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic          found;
    logic [AW-1:0] position;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t                         op;
    logic [AW-1:0]               slot;
    logic signed [WORD_BITS-1:0] value;
    logic signed [BND_W-1:0]     hi_init;
  } cmd_t;

endpackage

>>> rtl/tss_front.sv
// Front end: takes input items, holds the length register and builds commands.
module tss_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  tss_pkg::in_item_t    in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [tss_pkg::LEN_W-1:0] cfg_data,
  output logic                 q_push,
  input  logic                 q_full,
  output tss_pkg::cmd_t        q_cmd
);
  import tss_pkg::*;

  logic [LEN_W-1:0] used_length_r;
  logic [LEN_W-1:0] len_clip;

  // Length register, written on each config transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      used_length_r <= cfg_data;
    end
  end

  // Clip the length to the store size and derive the upper bound
  always_comb begin
    if (used_length_r > LEN_W'(DEPTH)) begin
      len_clip = LEN_W'(DEPTH);
    end else begin
      len_clip = used_length_r;
    end
  end

  // Build the command and push it on each input transfer
  always_comb begin
    q_cmd.op      = op_t'(in_item.kind);
    q_cmd.slot    = in_item.slot;
    q_cmd.value   = in_item.value;
    q_cmd.hi_init = $signed({1'b0, len_clip}) - $signed(BND_W'(1));
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

endmodule

>>> rtl/tss_queue.sv
// Short command queue decoupling the front end from the search engine.
module tss_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  tss_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output logic          empty,
  output tss_pkg::cmd_t rd_cmd
);
  import tss_pkg::*;

  cmd_t             slots_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slots_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/tss_back.sv
// Back end: element store and the ternary search sequencer with result register.
module tss_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  tss_pkg::cmd_t        q_cmd,
  output logic                 out_empty,
  input  logic                 out_pop,
  output tss_pkg::out_item_t   out_item
);
  import tss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_CMP,
    S_FINISH
  } state_t;

  localparam int PW = AW + RECIP_SH;

  logic signed [WORD_BITS-1:0] mem [DEPTH];
  logic signed [WORD_BITS-1:0] rd_a_r;
  logic signed [WORD_BITS-1:0] rd_b_r;

  state_t                      state_r;
  logic signed [BND_W-1:0]     lo_r;
  logic signed [BND_W-1:0]     hi_r;
  logic signed [BND_W-1:0]     m1_r;
  logic signed [BND_W-1:0]     m2_r;
  logic [AW-1:0]               third_r;
  logic signed [WORD_BITS-1:0] target_r;
  logic                        found_r;
  logic [AW-1:0]               pos_r;
  logic                        res_valid_r;
  out_item_t                   res_r;

  logic signed [BND_W-1:0]     diff;
  logic [PW-1:0]               prod;
  logic signed [BND_W-1:0]     m1;
  logic signed [BND_W-1:0]     m2;
  logic                        res_free;
  logic                        res_load;
  logic                        do_store;
  logic                        do_read;

  // Window width divided by three through a reciprocal multiply
  assign diff = hi_r - lo_r;
  assign prod = PW'(diff[AW-1:0]) * PW'(RECIP3);

  // Probe points from the registered window
  assign m1 = lo_r + $signed({1'b0, third_r});
  assign m2 = hi_r - $signed({1'b0, third_r});

  assign res_free  = !res_valid_r || out_pop;
  assign res_load  = (state_r == S_FINISH) && res_free;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign do_store  = q_pop && (q_cmd.op == OP_STORE);
  assign do_read   = (state_r == S_READ);
  assign out_empty = !res_valid_r;
  assign out_item  = res_r;

  // Element store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[q_cmd.slot] <= q_cmd.value;
    end
    if (do_read) begin
      rd_a_r <= mem[m1[AW-1:0]];
      rd_b_r <= mem[m2[AW-1:0]];
    end
  end

  // Search sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      // Drop the popped result unless a new one loads in its place
      if (out_pop && !res_load) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop && (q_cmd.op == OP_SEARCH)) begin
            target_r <= q_cmd.value;
            lo_r     <= '0;
            hi_r     <= q_cmd.hi_init;
            found_r  <= 1'b0;
            pos_r    <= '0;
            state_r  <= S_SETUP;
          end
        end
        S_SETUP: begin
          // Window empty: report absent
          if (lo_r > hi_r) begin
            state_r <= S_FINISH;
          end else begin
            third_r <= prod[PW-1:RECIP_SH];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          m1_r    <= m1;
          m2_r    <= m2;
          state_r <= S_CMP;
        end
        S_CMP: begin
          // Check left probe, then right probe, else narrow
          if (rd_a_r == target_r) begin
            found_r <= 1'b1;
            pos_r   <= m1_r[AW-1:0];
            state_r <= S_FINISH;
          end else if (rd_b_r == target_r) begin
            found_r <= 1'b1;
            pos_r   <= m2_r[AW-1:0];
            state_r <= S_FINISH;
          end else begin
            if (target_r < rd_a_r) begin
              hi_r <= m1_r - $signed(BND_W'(1));
            end else if (target_r > rd_b_r) begin
              lo_r <= m2_r + $signed(BND_W'(1));
            end else begin
              lo_r <= m1_r + $signed(BND_W'(1));
              hi_r <= m2_r - $signed(BND_W'(1));
            end
            state_r <= S_SETUP;
          end
        end
        S_FINISH: begin
          // Hold until the result register is free
          if (res_load) begin
            res_r.found    <= found_r;
            res_r.position <= pos_r;
            res_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/ternary_search_sorted_array_unit.sv
// Ternary search unit: store and search items in, one result per search out.
//
// Input queue side: drive in_item and raise in_push; the item transfers on a
// clock edge with in_push high and in_full low. kind 0 writes value at slot
// and gives no result; kind 1 searches indices 0 .. used_length-1 (length clipped to 1024) for value.
// Result queue side: while out_empty is low, out_item holds the oldest result;
// it transfers on an edge with out_pop high. If the receiver does not pop, the
// result waits and the engine stalls before writing the next one, while the
// two-entry command queue keeps taking input items until it fills.
// Config side: cfg_data is written to used_length on cfg_valid (cfg_ready is
// always high); write it only when no search is in flight.
// Sequencing: a store is written as the engine pops it. A search runs narrowing
// rounds (window divide, dual-port store read, compare) after entry from idle
// and before result handoff; the engine takes no new command until the search
// ends, as set by the engine's single round loop.
// Reset (rst_n low, synchronous) empties the queue and result register and
// clears used_length; store contents stay undefined until written.
module ternary_search_sorted_array_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  tss_pkg::in_item_t         in_item,
  output logic                      out_empty,
  input  logic                      out_pop,
  output tss_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tss_pkg::LEN_W-1:0] cfg_data
);
  import tss_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;

  tss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_cmd     (q_wr_cmd)
  );

  tss_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .full   (q_full),
    .wr_cmd (q_wr_cmd),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_rd_cmd)
  );

  tss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (q_rd_cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

>>> rtl/tss_checker.sv
// Port-level checker for the ternary search unit, bound to the top level.
module tss_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_push,
  input logic                      in_full,
  input tss_pkg::in_item_t         in_item,
  input logic                      out_empty,
  input logic                      out_pop,
  input tss_pkg::out_item_t        out_item,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [tss_pkg::LEN_W-1:0] cfg_data
);

  // Reset leaves no result and room for input
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("result or full flag set after reset");

  // A waiting result stays put until popped
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed before pop");

  // Absent target reports position zero
  a_absent_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.found) |-> (out_item.position == '0))
    else $error("nonzero position on a miss");

  // A blocked input item is held until it transfers
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && in_full) |=> (in_push && $stable(in_item)))
    else $error("blocked input item dropped or changed");

  // Config channel never backpressures and carries known data
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready && (!cfg_valid || !$isunknown(cfg_data)))
    else $error("config ready dropped or unknown config data");

endmodule

bind ternary_search_sorted_array_unit tss_checker u_tss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .in_item   (in_item),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);

>>> sim/ternary_search_sorted_array_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the ternary search unit: search scoreboard plus directed and random traffic.

// Mirror of the element store and length register; predicts one result per search
class search_scoreboard;
  logic signed [tss_pkg::WORD_BITS-1:0] elems [tss_pkg::DEPTH];
  logic [tss_pkg::LEN_W-1:0]            used_len;
  tss_pkg::out_item_t                   expected_lookups [$];
  int errors;
  int store_count;
  int search_count;
  int hit_count;

  function new();
    used_len     = '0;
    errors       = 0;
    store_count  = 0;
    search_count = 0;
    hit_count    = 0;
  endfunction

  // Walk the same narrowing steps as the block, sorted store or not
  function tss_pkg::out_item_t locate(logic signed [tss_pkg::WORD_BITS-1:0] target);
    int span, lo, hi, m1, m2;
    bit done;
    logic signed [tss_pkg::WORD_BITS-1:0] a, b;
    tss_pkg::out_item_t r;
    r    = '0;
    done = 0;
    span = used_len;
    if (span > tss_pkg::DEPTH) span = tss_pkg::DEPTH;
    lo = 0;
    hi = span - 1;
    while (!done && lo <= hi) begin
      m1 = lo + (hi - lo) / 3;
      m2 = hi - (hi - lo) / 3;
      a  = elems[m1];
      b  = elems[m2];
      if (a == target) begin
        r.found    = 1'b1;
        r.position = m1[tss_pkg::AW-1:0];
        done       = 1;
      end else if (b == target) begin
        r.found    = 1'b1;
        r.position = m2[tss_pkg::AW-1:0];
        done       = 1;
      end else if (target < a) begin
        hi = m1 - 1;
      end else if (target > b) begin
        lo = m2 + 1;
      end else begin
        lo = m1 + 1;
        hi = m2 - 1;
      end
    end
    return r;
  endfunction

  // Apply a store, or queue the answer a search must give
  function void note_transfer(tss_pkg::in_item_t it);
    if (it.kind == tss_pkg::OP_STORE) begin
      elems[it.slot] = it.value;
      store_count++;
    end else begin
      expected_lookups.push_back(locate(it.value));
      search_count++;
    end
  endfunction

  // Compare a popped result with the oldest expected answer
  function void check_lookup(tss_pkg::out_item_t got);
    tss_pkg::out_item_t want;
    if (expected_lookups.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual found=%0d position=%0d",
               $time, got.found, got.position);
      return;
    end
    want = expected_lookups.pop_front();
    if (got.found !== want.found) begin
      errors++;
      $display("%0t: found mismatch: expected %0d, actual %0d", $time, want.found, got.found);
    end
    if (got.position !== want.position) begin
      errors++;
      $display("%0t: position mismatch: expected %0d, actual %0d",
               $time, want.position, got.position);
    end
    if (want.found) hit_count++;
  endfunction
endclass

module ternary_search_sorted_array_unit_tb;
  import tss_pkg::*;

  localparam int LIMIT     = 400000;
  localparam int SETTLE    = 64;
  localparam int ITEM_GOAL = 1900;
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = 32'sh80000000;
  localparam logic signed [WORD_BITS-1:0] WORD_MAX = 32'sh7fffffff;

  logic             clk;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  in_item_t         in_item;
  logic             out_empty;
  logic             out_pop;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;

  search_scoreboard sb;
  bit               no_gaps;
  int unsigned      cycle_count = 0;
  int               sent = 0;
  int               length_writes = 0;

  ternary_search_sorted_array_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Push one item after a random gap; hold push high across back-to-back transfers
  task automatic send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    sb.note_transfer(it);
    sent++;
  endtask

  task automatic store_word(int slot, logic signed [WORD_BITS-1:0] v);
    in_item_t it;
    it.kind  = OP_STORE;
    it.slot  = slot[AW-1:0];
    it.value = v;
    send_item(it);
  endtask

  task automatic search_for(logic signed [WORD_BITS-1:0] v);
    in_item_t it;
    it.kind  = OP_SEARCH;
    it.slot  = AW'($urandom);
    it.value = v;
    send_item(it);
  endtask

  // Stop sending, wait out every pending result, then let trailing stores finish
  task automatic wait_drained();
    in_push <= 1'b0;
    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_length(int n);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= n[LEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    sb.used_len  = n[LEN_W-1:0];
    length_writes++;
  endtask

  // Write slots 0 .. n-1 in ascending order; small steps give repeated values
  task automatic fill_sorted(int n, longint start, int unsigned step_max);
    longint acc;
    acc = start;
    for (int i = 0; i < n; i++) begin
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      store_word(i, acc[WORD_BITS-1:0]);
      acc += $urandom_range(0, step_max);
    end
  endtask

  // Mostly hits and near misses on the searched range, some arbitrary targets and stray stores
  task automatic run_searches(int count, int span);
    int sel, idx;
    logic signed [WORD_BITS-1:0] t;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) store_word($urandom_range(0, DEPTH - 1), $urandom);
      sel = $urandom_range(0, 99);
      idx = (span > 0) ? $urandom_range(0, span - 1) : 0;
      if (span > 0 && sel < 60) begin
        t = sb.elems[idx];
      end else if (span > 0 && sel < 75) begin
        t = sb.elems[idx] + ($urandom_range(0, 1) ? 1 : -1);
      end else begin
        t = $urandom;
      end
      search_for(t);
    end
  endtask

  // Pop results after random stalls and check each one
  task automatic drain_results();
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_lookup(out_item);
    end
  endtask

  initial begin
    int len, span, pick;
    sb = new();
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_item   <= '0;
    out_pop   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none

    // Empty length, from reset and written explicitly
    search_for(5);
    set_length(0);
    search_for(WORD_MIN);

    // Small sorted store with both word extremes and a repeated value
    store_word(0, WORD_MIN);
    store_word(1, -1000);
    store_word(2, -7);
    store_word(3, 0);
    store_word(4, 3);
    store_word(5, 3);
    store_word(6, 900);
    store_word(7, WORD_MAX);
    store_word(DEPTH - 1, 32'sh5a5a5a5a);
    set_length(8);
    search_for(WORD_MIN);
    search_for(WORD_MAX);
    search_for(-7);
    search_for(3);
    search_for(0);
    search_for(-5);
    search_for(WORD_MAX - 1);

    // Single element window
    set_length(1);
    search_for(WORD_MIN);
    search_for(0);

    // Break the ordering and search across the disturbed entry
    store_word(2, 5000);
    set_length(8);
    search_for(5000);
    search_for(900);

    // Full store, then the full length and a length past the store depth
    no_gaps = 1'b0;
    fill_sorted(DEPTH, -64'sd2147483648, 8388607);
    set_length(DEPTH);
    run_searches(50, DEPTH);
    no_gaps = 1'b1;
    set_length(2047);
    run_searches(25, DEPTH);

    // Random phases: mostly short sorted windows, a few empty or full ones
    while (sent < ITEM_GOAL) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 19);
      if (pick == 0) len = 0;
      else if (pick == 1) len = DEPTH;
      else if (pick == 2) len = $urandom_range(DEPTH + 1, 2047);
      else len = $urandom_range(1, 48);
      span = (len > DEPTH) ? DEPTH : len;
      if (span > 0 && span <= 48) begin
        if ($urandom_range(0, 5) == 0) begin
          for (int i = 0; i < span; i++) store_word(i, $urandom);
        end else begin
          fill_sorted(span, longint'($signed($urandom)),
                      $urandom_range(0, 1) ? 3 : (1 << $urandom_range(4, 24)));
        end
      end
      set_length(len);
      run_searches($urandom_range(10, 30), span);
    end

    wait_drained();
    $display("Run covered %0d store and %0d search transfers (%0d hits) over %0d length writes.",
             sb.store_count, sb.search_count, sb.hit_count, length_writes);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
